/* rtl/imda_pkg.sv */
package imda_pkg;

  // operand width used by the arithmetic; ports stay 64 bits
  localparam int W = 64;
  localparam int CW = $clog2(W);

  // opcodes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_ABS = 3'd5;

  // iteration counts, loaded as count minus one
  localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(W - 2);

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } imda_cmd_t;

  typedef struct packed {
    logic long_op;
    logic mul_op;
  } imda_stat_t;

endpackage

/* rtl/imda_ctrl.sv */
module imda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  imda_pkg::imda_stat_t stat,
  output imda_pkg::imda_cmd_t  cmd
);
  import imda_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;
  logic          out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // sequencing of load, iterations and result hand-off
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          cnt_nxt   = stat.mul_op ? MUL_LAST : DIV_LAST;
          state_nxt = stat.long_op ? S_RUN : S_FIN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/imda_dp.sv */
module imda_dp (
  input  logic                 clk,
  input  logic [2:0]           in_opcode,
  input  logic signed [63:0]   in_operand_a,
  input  logic signed [63:0]   in_operand_b,
  input  imda_pkg::imda_cmd_t  cmd,
  output imda_pkg::imda_stat_t stat,
  output logic signed [63:0]   out_result,
  output logic [62:0]          out_remainder,
  output logic                 out_error
);
  import imda_pkg::*;

  logic [W-1:0] a, b, mag_a, mag_b, quick;
  logic         sa, sb, is_mul, is_div, div_bad;

  logic [W-1:0] x_r, y_r, acc_r, q_r;
  logic         mul_r, div_r, neg_r, err_r;

  logic [W-1:0] r_sh, r_dif;
  logic         r_ge;
  logic [W-1:0] fin_res;
  logic [W-2:0] fin_rem;

  logic [W-1:0] res_r;
  logic [W-2:0] rem_r;
  logic         oerr_r;

  // operand decode
  assign a       = in_operand_a[W-1:0];
  assign b       = in_operand_b[W-1:0];
  assign sa      = a[W-1];
  assign sb      = b[W-1];
  assign mag_a   = sa ? (W'(0) - a) : a;
  assign mag_b   = sb ? (W'(0) - b) : b;
  assign is_mul  = (in_opcode == OP_MUL);
  assign is_div  = (in_opcode == OP_DIV);
  assign div_bad = sa || sb;

  assign stat.mul_op  = is_mul;
  assign stat.long_op = is_mul || (is_div && !div_bad);

  // operations without iteration, computed combinationally
  always_comb begin
    case (in_opcode)
      OP_ADD:  quick = a + b;
      OP_SUB:  quick = a - b;
      OP_NEG:  quick = W'(0) - a;
      OP_ABS:  quick = mag_a;
      default: quick = '0;
    endcase
  end

  // one restoring division step
  assign r_sh  = {acc_r[W-2:0], x_r[W-2]};
  assign r_ge  = (r_sh >= y_r);
  assign r_dif = r_sh - y_r;

  // final selection
  always_comb begin
    fin_res = acc_r;
    fin_rem = '0;
    if (mul_r) begin
      fin_res = neg_r ? (W'(0) - acc_r) : acc_r;
    end else if (div_r) begin
      fin_res = q_r;
      fin_rem = acc_r[W-2:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mul_r <= is_mul;
      div_r <= is_div && !div_bad;
      neg_r <= sa ^ sb;
      q_r   <= '0;
      if (is_mul) begin
        x_r   <= mag_a;
        y_r   <= mag_b;
        acc_r <= '0;
        err_r <= 1'b0;
      end else if (is_div) begin
        x_r   <= a;
        y_r   <= b;
        acc_r <= '0;
        err_r <= div_bad || (b == '0);
      end else begin
        x_r   <= a;
        y_r   <= b;
        acc_r <= quick;
        err_r <= 1'b0;
      end
    end else if (cmd.step) begin
      x_r <= {x_r[W-2:0], 1'b0};
      if (mul_r) begin
        y_r <= {1'b0, y_r[W-1:1]};
        if (y_r[0]) begin
          acc_r <= acc_r + x_r;
        end
      end else begin
        acc_r <= r_ge ? r_dif : r_sh;
        q_r   <= {q_r[W-2:0], r_ge};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r  <= fin_res;
      rem_r  <= fin_rem;
      oerr_r <= err_r;
    end
  end

  assign out_result    = 64'($signed(res_r));
  assign out_remainder = 63'(rem_r);
  assign out_error     = oerr_r;

endmodule

/* rtl/integer_mul_div_alu.sv */
// channel  | ports                                                          | dir
// ---------+----------------------------------------------------------------+-----
// input    | in_valid/in_ready, in_opcode, in_operand_a, in_operand_b       | in
// result   | out_valid/out_ready, out_result, out_remainder, out_error      | out
//
// add, subtract, negate, abs, unused codes and negative-operand divides: load and finish;
// the result is registered in the finish state that follows the load.
// multiply: 64 shift-add iterations plus load and finish.
// divide (zero divisor included): 63 restoring steps plus load and finish.
// one item in the engine at a time; the next item is taken while a result waits,
// and a stalled result holds the engine in its finish state until out_ready.
// synchronous active-low reset clears the controller; data registers are not reset.
module integer_mul_div_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_result,
  output logic [62:0]        out_remainder,
  output logic               out_error
);
  import imda_pkg::*;

  imda_cmd_t  cmd;
  imda_stat_t stat;

  // sequencer
  imda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic datapath
  imda_dp u_dp (
    .clk           (clk),
    .in_opcode     (in_opcode),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .cmd           (cmd),
    .stat          (stat),
    .out_result    (out_result),
    .out_remainder (out_remainder),
    .out_error     (out_error)
  );

endmodule
